/* design/jtm_pkg.sv */
`timescale 1ns / 1ps
package jtm_pkg;

  localparam int SAMPLE_MAX      = 2047;
  localparam int DIGITIZER_RANGE = 4095;
  localparam int SCREEN_H        = 9;
  localparam int SCREEN_W        = 16;
  localparam int SLOTS           = 8;

  localparam int SAMPLE_W  = 11;
  localparam int PCT_W     = 7;
  localparam int VEL_W     = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int POS_W     = 16;
  localparam int SLOT_W    = 8;
  localparam int SLOT_IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [SLOT_W-1:0] NO_SLOT = 8'hFF;

  localparam logic [PCT_W-1:0] RST_CENTER   = 7'd50;
  localparam logic [PCT_W-1:0] RST_RADIUS   = 7'd10;
  localparam logic [PCT_W-1:0] RST_DEADZONE = 7'd10;
  localparam logic [VEL_W-1:0] RST_VELOCITY = 8'd10;

  localparam int HALF    = (SAMPLE_MAX / 2 > 0) ? SAMPLE_MAX / 2 : 1;
  localparam int PCT     = 100;
  localparam int DR_Q    = DIGITIZER_RANGE / PCT;
  localparam int DR_R    = DIGITIZER_RANGE % PCT;
  localparam int RATIO_D = SCREEN_W * HALF;

  // shared multiplier and reciprocal divide
  localparam int     MUL_W   = 24;
  localparam int     PROD_W  = 2 * MUL_W;
  localparam longint DIV_ONE = longint'(1) << MUL_W;

  localparam logic [MUL_W-1:0] RECIP_PCT   = MUL_W'(DIV_ONE / PCT);
  localparam logic [MUL_W-1:0] RECIP_HALF  = MUL_W'(DIV_ONE / HALF);
  localparam logic [MUL_W-1:0] RECIP_RATIO = MUL_W'(DIV_ONE / RATIO_D);

  typedef enum logic [1:0] {
    DIV_PCT,
    DIV_HALF,
    DIV_RATIO
  } div_sel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_CENTER_X,
    REG_LEFT_CENTER_Y,
    REG_LEFT_RADIUS,
    REG_RIGHT_CENTER_X,
    REG_RIGHT_CENTER_Y,
    REG_RIGHT_VELOCITY,
    REG_DEADZONE_PERCENT
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_THR_MUL,
    ST_DIV_Q,
    ST_DIV_R,
    ST_DIV_FIX,
    ST_TSQ,
    ST_LSQX,
    ST_LSQY,
    ST_RSQX,
    ST_RSQY,
    ST_LX_MUL,
    ST_LX_RATIO,
    ST_LX_SUM,
    ST_LX_SCALE,
    ST_LX_DONE,
    ST_LY_MUL,
    ST_LY_SUM,
    ST_LY_SCALE,
    ST_LY_DONE,
    ST_RCX,
    ST_RCX_DONE,
    ST_RCY,
    ST_RCY_DONE,
    ST_RX_MUL1,
    ST_RX_MUL2,
    ST_RX_DONE,
    ST_RY_MUL,
    ST_RY_DONE,
    ST_UPD_L,
    ST_UPD_R,
    ST_SEND
  } st_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] left_x;
    logic [SAMPLE_W-1:0] left_y;
    logic [SAMPLE_W-1:0] right_x;
    logic [SAMPLE_W-1:0] right_y;
  } sample_t;

  typedef struct packed {
    logic              pressed;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic              last;
  } report_t;

  typedef struct packed {
    logic              claim;
    logic              drop;
    logic [SLOT_W-1:0] slot;
  } slot_cmd_t;

  typedef struct packed {
    logic                neg;
    logic [SAMPLE_W-1:0] mag;
  } offset_t;

  function automatic logic [MUL_W-1:0] div_const(input div_sel_t sel);
    unique case (sel)
      DIV_PCT:   return MUL_W'(PCT);
      DIV_HALF:  return MUL_W'(HALF);
      DIV_RATIO: return MUL_W'(RATIO_D);
      default:   return MUL_W'(PCT);
    endcase
  endfunction

  function automatic logic [MUL_W-1:0] div_recip(input div_sel_t sel);
    unique case (sel)
      DIV_PCT:   return RECIP_PCT;
      DIV_HALF:  return RECIP_HALF;
      DIV_RATIO: return RECIP_RATIO;
      default:   return RECIP_PCT;
    endcase
  endfunction

  function automatic offset_t centre_offset(input logic [SAMPLE_W-1:0] x);
    offset_t o;
    if (x < SAMPLE_W'(HALF)) begin
      o.neg = 1'b1;
      o.mag = SAMPLE_W'(HALF) - x;
    end else begin
      o.neg = 1'b0;
      o.mag = x - SAMPLE_W'(HALF);
    end
    return o;
  endfunction

  function automatic logic [SLOT_W-1:0] lowest_free(input logic [SLOTS-1:0] used);
    logic [SLOT_W-1:0] idx;
    idx = NO_SLOT;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) idx = SLOT_W'(i);
    end
    return idx;
  endfunction

endpackage

/* design/jtm_intf.sv */
`timescale 1ns / 1ps
interface jtm_in_if;
  import jtm_pkg::*;

  logic    valid;
  logic    ready;
  sample_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface jtm_out_if;
  import jtm_pkg::*;

  logic    valid;
  logic    ready;
  report_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/jtm_slot_alloc.sv */
`timescale 1ns / 1ps
module jtm_slot_alloc (
  input  logic                       clk,
  input  logic                       rst,
  input  jtm_pkg::slot_cmd_t         cmd,
  output logic [jtm_pkg::SLOT_W-1:0] free_slot
);
  import jtm_pkg::*;

  logic [SLOTS-1:0]  used;
  logic [SLOTS-1:0]  used_next;
  logic [SLOT_W-1:0] nf;

  // claim marks the lowest free bit, drop clears an in-range slot
  always_comb begin
    used_next = used;
    if (cmd.claim) begin
      used_next = used | (~used & (used + SLOTS'(1)));
    end else if (cmd.drop && (cmd.slot < SLOT_W'(SLOTS))) begin
      used_next = used & ~(SLOTS'(1) << cmd.slot[SLOT_IW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      nf   <= '0;
    end else if (cmd.claim || cmd.drop) begin
      used <= used_next;
      nf   <= lowest_free(used_next);
    end
  end

  assign free_slot = nf;

  a_nf_free: assert property (@(posedge clk) disable iff (rst)
    (nf != NO_SLOT) |-> !used[nf[SLOT_IW-1:0]])
    else $error("next free slot is marked used");

  a_nf_full: assert property (@(posedge clk) disable iff (rst)
    (nf == NO_SLOT) |-> (&used))
    else $error("no free slot reported while map has a hole");

  a_claim_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.claim && nf != NO_SLOT) |=> ($countones(used) == $past($countones(used)) + 1))
    else $error("claim did not take exactly one slot");

endmodule

/* design/joystick_to_touch_mapper_core.sv */
`timescale 1ns / 1ps
// flow: an input beat is taken in idle and runs the multiplier sequence; the report beats
// (0 to 2) then leave one per cycle while touch.ready is high, and no new input beat is taken
// until the last is sent; the single shared 24x24 multiplier does the reciprocal divisions
// reset: synchronous, active high; configuration returns to its defaults, sticks inactive,
// all touch slots free; ready for an input beat as soon as reset drops
module joystick_to_touch_mapper_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [jtm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jtm_pkg::CFG_W-1:0]     cfg_data,
  jtm_in_if.sink                        joy,
  jtm_out_if.source                     touch
);
  import jtm_pkg::*;

  // configuration
  logic [PCT_W-1:0] lcx, lcy, lrad, rcx, rcy, dz;
  logic [VEL_W-1:0] rvel;

  // sequencer
  st_t      st, st_next, ret;
  div_sel_t dsel;

  // datapath
  sample_t           smp;
  offset_t           ofs_lx, ofs_ly, ofs_rx, ofs_ry;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] p;
  logic [MUL_W-1:0]  num, q0, quo, tsq, sq;
  logic              lout, rout;
  logic [POS_W-1:0]  ureg, scaled, lx_ofs;
  logic [POS_W-1:0]  lpx_new, lpy_new, rsx, rsy, sx, sy;

  // stick state
  logic              lact, ract;
  logic [SLOT_W-1:0] ls, rs, ls_eff, rs_eff, free_slot;
  logic [POS_W-1:0]  lpx, lpy, rpx, rpy;
  logic [POS_W-1:0]  rbase_x, rbase_y, rpx_n, rpy_n;

  // report buffer
  report_t   rep [2];
  report_t   lrep, rrep;
  logic      lrep_en, rrep_en;
  logic [1:0] nrep;
  logic      ridx;
  logic      last_beat;

  slot_cmd_t slot_cmd;

  jtm_slot_alloc u_slots (
    .clk       (clk),
    .rst       (rst),
    .cmd       (slot_cmd),
    .free_slot (free_slot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lcx  <= RST_CENTER;
      lcy  <= RST_CENTER;
      lrad <= RST_RADIUS;
      rcx  <= RST_CENTER;
      rcy  <= RST_CENTER;
      rvel <= RST_VELOCITY;
      dz   <= RST_DEADZONE;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LEFT_CENTER_X:    lcx  <= cfg_data[PCT_W-1:0];
        REG_LEFT_CENTER_Y:    lcy  <= cfg_data[PCT_W-1:0];
        REG_LEFT_RADIUS:      lrad <= cfg_data[PCT_W-1:0];
        REG_RIGHT_CENTER_X:   rcx  <= cfg_data[PCT_W-1:0];
        REG_RIGHT_CENTER_Y:   rcy  <= cfg_data[PCT_W-1:0];
        REG_RIGHT_VELOCITY:   rvel <= cfg_data[VEL_W-1:0];
        REG_DEADZONE_PERCENT: dz   <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ofs_lx = centre_offset(smp.left_x);
    ofs_ly = centre_offset(smp.left_y);
    ofs_rx = centre_offset(smp.right_x);
    ofs_ry = centre_offset(smp.right_y);
  end

  // percent to digitizer units: u*R/100 = u*(R/100) + u*(R%100)/100
  assign scaled = POS_W'(ureg * DR_Q) + quo[POS_W-1:0];
  assign lx_ofs = POS_W'(p[MUL_W-1:0] / SCREEN_W);

  always_comb begin
    ls_eff  = lact ? ls : free_slot;
    rs_eff  = ract ? rs : free_slot;
    lrep_en = lout || lact;
    rrep_en = rout || ract;
    rbase_x = ract ? rpx : rsx;
    rbase_y = ract ? rpy : rsy;
    rpx_n   = ofs_rx.neg ? rbase_x - sx : rbase_x + sx;
    rpy_n   = ofs_ry.neg ? rbase_y - sy : rbase_y + sy;
    if (lout) begin
      lrep = '{pressed: 1'b1, slot: ls_eff, pos_x: lpx_new, pos_y: lpy_new, last: 1'b0};
    end else begin
      lrep = '{pressed: 1'b0, slot: ls, pos_x: lpx, pos_y: lpy, last: 1'b0};
    end
    if (rout) begin
      rrep = '{pressed: 1'b1, slot: rs_eff, pos_x: rpx_n, pos_y: rpy_n, last: 1'b0};
    end else begin
      rrep = '{pressed: 1'b0, slot: rs, pos_x: rpx, pos_y: rpy, last: 1'b0};
    end
    last_beat = ({1'b0, ridx} == (nrep - 2'd1));
  end

  // next state
  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE:     if (joy.valid) st_next = ST_THR_MUL;
      ST_THR_MUL:  st_next = ST_DIV_Q;
      ST_DIV_Q:    st_next = ST_DIV_R;
      ST_DIV_R:    st_next = ST_DIV_FIX;
      ST_DIV_FIX:  st_next = ret;
      ST_TSQ:      st_next = ST_LSQX;
      ST_LSQX:     st_next = ST_LSQY;
      ST_LSQY:     st_next = ST_RSQX;
      ST_RSQX:     st_next = ST_RSQY;
      ST_RSQY:     st_next = ST_LX_MUL;
      ST_LX_MUL:   st_next = ST_DIV_Q;
      ST_LX_RATIO: st_next = ST_LX_SUM;
      ST_LX_SUM:   st_next = ST_LX_SCALE;
      ST_LX_SCALE: st_next = ST_DIV_Q;
      ST_LX_DONE:  st_next = ST_LY_MUL;
      ST_LY_MUL:   st_next = ST_DIV_Q;
      ST_LY_SUM:   st_next = ST_LY_SCALE;
      ST_LY_SCALE: st_next = ST_DIV_Q;
      ST_LY_DONE:  st_next = ST_RCX;
      ST_RCX:      st_next = ST_DIV_Q;
      ST_RCX_DONE: st_next = ST_RCY;
      ST_RCY:      st_next = ST_DIV_Q;
      ST_RCY_DONE: st_next = ST_RX_MUL1;
      ST_RX_MUL1:  st_next = ST_RX_MUL2;
      ST_RX_MUL2:  st_next = ST_DIV_Q;
      ST_RX_DONE:  st_next = ST_RY_MUL;
      ST_RY_MUL:   st_next = ST_DIV_Q;
      ST_RY_DONE:  st_next = ST_UPD_L;
      ST_UPD_L:    st_next = ST_UPD_R;
      ST_UPD_R:    st_next = (nrep != 2'd0 || rrep_en) ? ST_SEND : ST_IDLE;
      ST_SEND:     if (touch.ready && last_beat) st_next = ST_IDLE;
      default:     st_next = ST_IDLE;
    endcase
  end

  // outputs: handshake, multiplier operands, slot commands
  always_comb begin
    joy.ready       = (st == ST_IDLE);
    touch.valid     = (st == ST_SEND);
    touch.data      = rep[ridx];
    touch.data.last = last_beat;
    mul_a           = '0;
    mul_b           = '0;
    slot_cmd        = '{claim: 1'b0, drop: 1'b0, slot: ls};
    unique case (st)
      ST_THR_MUL: begin
        mul_a = MUL_W'(SAMPLE_MAX);
        mul_b = MUL_W'(dz);
      end
      ST_DIV_Q: begin
        mul_a = p[MUL_W-1:0];
        mul_b = div_recip(dsel);
      end
      ST_DIV_R: begin
        mul_a = p[PROD_W-1:MUL_W];
        mul_b = div_const(dsel);
      end
      ST_TSQ: begin
        mul_a = quo;
        mul_b = quo;
      end
      ST_LSQX: begin
        mul_a = MUL_W'(ofs_lx.mag);
        mul_b = MUL_W'(ofs_lx.mag);
      end
      ST_LSQY: begin
        mul_a = MUL_W'(ofs_ly.mag);
        mul_b = MUL_W'(ofs_ly.mag);
      end
      ST_RSQX: begin
        mul_a = MUL_W'(ofs_rx.mag);
        mul_b = MUL_W'(ofs_rx.mag);
      end
      ST_RSQY: begin
        mul_a = MUL_W'(ofs_ry.mag);
        mul_b = MUL_W'(ofs_ry.mag);
      end
      ST_LX_MUL: begin
        mul_a = MUL_W'(lrad);
        mul_b = MUL_W'(ofs_lx.mag);
      end
      ST_LX_RATIO: begin
        mul_a = quo;
        mul_b = MUL_W'(SCREEN_H);
      end
      ST_LX_SCALE, ST_LY_SCALE: begin
        mul_a = MUL_W'(ureg);
        mul_b = MUL_W'(DR_R);
      end
      ST_LY_MUL: begin
        mul_a = MUL_W'(lrad);
        mul_b = MUL_W'(ofs_ly.mag);
      end
      ST_RCX: begin
        mul_a = MUL_W'(rcx);
        mul_b = MUL_W'(DR_R);
      end
      ST_RCY: begin
        mul_a = MUL_W'(rcy);
        mul_b = MUL_W'(DR_R);
      end
      ST_RX_MUL1: begin
        mul_a = MUL_W'(ofs_rx.mag);
        mul_b = MUL_W'(SCREEN_H);
      end
      ST_RX_MUL2: begin
        mul_a = p[MUL_W-1:0];
        mul_b = MUL_W'(rvel);
      end
      ST_RY_MUL: begin
        mul_a = MUL_W'(ofs_ry.mag);
        mul_b = MUL_W'(rvel);
      end
      ST_UPD_L: begin
        slot_cmd = '{claim: lout && !lact, drop: !lout && lact, slot: ls};
      end
      ST_UPD_R: begin
        slot_cmd = '{claim: rout && !ract, drop: !rout && ract, slot: rs};
      end
      default: ;
    endcase
  end

  // control and stick state
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= ST_IDLE;
      lact <= 1'b0;
      ract <= 1'b0;
      ls   <= '0;
      rs   <= '0;
      lpx  <= '0;
      lpy  <= '0;
      rpx  <= '0;
      rpy  <= '0;
      nrep <= '0;
      ridx <= 1'b0;
    end else begin
      st <= st_next;
      case (st)
        ST_UPD_L: begin
          if (lout) begin
            lact <= 1'b1;
            ls   <= ls_eff;
            lpx  <= lpx_new;
            lpy  <= lpy_new;
          end else if (lact) begin
            lact <= 1'b0;
            ls   <= '0;
          end
          nrep <= {1'b0, lrep_en};
          ridx <= 1'b0;
        end
        ST_UPD_R: begin
          if (rout) begin
            ract <= 1'b1;
            rs   <= rs_eff;
            rpx  <= rpx_n;
            rpy  <= rpy_n;
          end else if (ract) begin
            ract <= 1'b0;
            rs   <= '0;
          end
          nrep <= nrep + {1'b0, rrep_en};
        end
        ST_SEND: if (touch.ready) ridx <= ridx + 1'b1;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    p <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (joy.valid && joy.ready) smp <= joy.data;
    case (st)
      ST_THR_MUL: begin
        ret  <= ST_TSQ;
        dsel <= DIV_PCT;
      end
      ST_DIV_Q:   num <= p[MUL_W-1:0];
      ST_DIV_R:   q0  <= p[PROD_W-1:MUL_W];
      // reciprocal estimate is low by at most one
      ST_DIV_FIX: quo <= ((num - p[MUL_W-1:0]) >= div_const(dsel)) ? q0 + 1'b1 : q0;
      ST_LSQX:    tsq <= p[MUL_W-1:0];
      ST_LSQY:    sq  <= p[MUL_W-1:0];
      ST_RSQX:    lout <= (sq + p[MUL_W-1:0]) >= tsq;
      ST_RSQY:    sq  <= p[MUL_W-1:0];
      ST_LX_MUL: begin
        rout <= (sq + p[MUL_W-1:0]) >= tsq;
        ret  <= ST_LX_RATIO;
        dsel <= DIV_HALF;
      end
      ST_LX_SUM: ureg <= ofs_lx.neg ? POS_W'(lcx) - lx_ofs : POS_W'(lcx) + lx_ofs;
      ST_LX_SCALE: begin
        ret  <= ST_LX_DONE;
        dsel <= DIV_PCT;
      end
      ST_LX_DONE: lpx_new <= scaled;
      ST_LY_MUL: begin
        ret  <= ST_LY_SUM;
        dsel <= DIV_HALF;
      end
      ST_LY_SUM: begin
        ureg <= ofs_ly.neg ? POS_W'(lcy) - quo[POS_W-1:0] : POS_W'(lcy) + quo[POS_W-1:0];
      end
      ST_LY_SCALE: begin
        ret  <= ST_LY_DONE;
        dsel <= DIV_PCT;
      end
      ST_LY_DONE: lpy_new <= scaled;
      ST_RCX: begin
        ureg <= POS_W'(rcx);
        ret  <= ST_RCX_DONE;
        dsel <= DIV_PCT;
      end
      ST_RCX_DONE: rsx <= scaled;
      ST_RCY: begin
        ureg <= POS_W'(rcy);
        ret  <= ST_RCY_DONE;
        dsel <= DIV_PCT;
      end
      ST_RCY_DONE: rsy <= scaled;
      ST_RX_MUL2: begin
        ret  <= ST_RX_DONE;
        dsel <= DIV_RATIO;
      end
      ST_RX_DONE: sx <= quo[POS_W-1:0];
      ST_RY_MUL: begin
        ret  <= ST_RY_DONE;
        dsel <= DIV_HALF;
      end
      ST_RY_DONE: sy <= quo[POS_W-1:0];
      ST_UPD_L:   if (lrep_en) rep[0] <= lrep;
      ST_UPD_R:   if (rrep_en) rep[nrep[0]] <= rrep;
      default: ;
    endcase
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(joy.ready && touch.valid))
    else $error("input taken while a report beat is pending");

  a_slots_distinct: assert property (@(posedge clk) disable iff (rst)
    (lact && ract && ls != NO_SLOT && rs != NO_SLOT) |-> (ls != rs))
    else $error("both sticks hold the same touch slot");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (touch.valid && touch.ready && touch.data.last) |=> joy.ready)
    else $error("not ready after the final report beat");

endmodule
